// ===== sv/mpc_steering_candidate_search_defines.svh =====
// assertion helpers used by the steering search controller
`ifndef MPC_STEERING_CANDIDATE_SEARCH_DEFINES_SVH
`define MPC_STEERING_CANDIDATE_SEARCH_DEFINES_SVH

// condition holds at every edge out of reset
`define MSCS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define MSCS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define MSCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mscs_pkg.sv =====
package mscs_pkg;

    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_ANGLE = 2'd1;
    localparam logic [1:0] REG_IWB   = 2'd2;

    localparam logic [15:0] RATE_RST  = 16'd2048;
    localparam logic [14:0] ANGLE_RST = 15'd8192;
    localparam logic [15:0] IWB_RST   = 16'd24272;

    localparam logic [14:0] SPEED_FLOOR    = 15'd256;
    localparam logic [13:0] COEF_POINT_TWO = 14'd13107;

    // candidate order: -full, -half, zero, +half, +full
    localparam logic [2:0] CAND_NEG_FULL = 3'd0;
    localparam logic [2:0] CAND_NEG_HALF = 3'd1;
    localparam logic [2:0] CAND_ZERO     = 3'd2;
    localparam logic [2:0] CAND_POS_HALF = 3'd3;
    localparam logic [2:0] CAND_POS_FULL = 3'd4;
    localparam logic [2:0] CAND_LAST     = CAND_POS_FULL;

    localparam logic signed [39:0] MODEL_MAX_W = 40'sd2147483647;
    localparam logic signed [31:0] MODEL_MAX   = 32'sd2147483647;

    typedef struct packed {
        logic       load;
        logic       prep1;
        logic       prep2;
        logic       cand_init;
        logic       cand_mul;
        logic       cand_cost;
        logic       step_head;
        logic       step_mul;
        logic       step_lat;
        logic       step_sq;
        logic       cand_end;
        logic       commit;
        logic [2:0] cand;
        logic       first;
    } mscs_cmd_t;

    typedef struct packed {
        logic dt_zero;
    } mscs_stat_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic signed [31:0] sat_model(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > MODEL_MAX_W)
            r = MODEL_MAX;
        else if (x < -MODEL_MAX_W)
            r = -MODEL_MAX;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== sv/mpc_steering_candidate_search.sv =====
// Sampling predictive steering search. One s_tdata transfer is one control tick; one m_tdata
// transfer returns the chosen steering command. A tick runs two prep states and then, for each
// of the five candidates, an init, multiply and cost state, the shared kinematic model step for
// every horizon step (heading update, multiply, lateral update, square) and an end state; a
// tick with zero step time skips from the first prep state straight to finish. Items are
// processed one at a time; a new tick is taken as soon as the search is idle, even while the
// previous result waits in the output register.
module mpc_steering_candidate_search #(
    parameter int HORIZON = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lateral_offset, head_error, vehicle_speed, step_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // steer_command
    output logic [0:0]  m_tuser,   // held
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] rate_reg;
    logic [14:0] angle_reg;
    logic [15:0] iwb_reg;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic                 accept;
    logic                 out_free;
    logic                 in_ready;
    mscs_pkg::mscs_cmd_t  cmd;
    mscs_pkg::mscs_stat_t stat;
    logic signed [15:0]   result_command;
    logic                 result_held;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= mscs_pkg::RATE_RST;
            angle_reg <= mscs_pkg::ANGLE_RST;
            iwb_reg   <= mscs_pkg::IWB_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mscs_pkg::REG_RATE:  rate_reg  <= cfg_data;
                mscs_pkg::REG_ANGLE: angle_reg <= cfg_data[14:0];
                mscs_pkg::REG_IWB:   iwb_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    mscs_ctrl #(
        .HORIZON (HORIZON)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    mscs_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .max_steer_rate    (rate_reg),
        .max_steer_angle   (angle_reg),
        .inverse_wheelbase (iwb_reg),
        .lateral_offset    (s_tdata[15:0]),
        .head_error        (s_tdata[31:16]),
        .vehicle_speed     (s_tdata[47:32]),
        .step_time         (s_tdata[63:48]),
        .result_command    (result_command),
        .result_held       (result_held)
    );

    // output register decouples the search from the downstream stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.commit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_tdata_reg <= result_command;
            m_tuser_reg <= result_held;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== sv/mscs_datapath.sv =====
module mscs_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mscs_pkg::mscs_cmd_t     cmd,
    output mscs_pkg::mscs_stat_t    stat,
    input  logic [15:0]             max_steer_rate,
    input  logic [14:0]             max_steer_angle,
    input  logic [15:0]             inverse_wheelbase,
    input  logic signed [15:0]      lateral_offset,
    input  logic signed [15:0]      head_error,
    input  logic signed [15:0]      vehicle_speed,
    input  logic [15:0]             step_time,
    output logic signed [15:0]      result_command,
    output logic                    result_held
);

    logic signed [31:0] lat0_reg;
    logic signed [31:0] head0_reg;
    logic [14:0]        speed_reg;
    logic [15:0]        dt_reg;

    logic [31:0]        prod_reg;
    logic [30:0]        swb_reg;
    logic [30:0]        lgain_reg;
    logic [18:0]        full_reg;
    logic [17:0]        half_reg;
    logic [46:0]        kin_reg;

    logic signed [15:0] c_reg;
    logic signed [16:0] d_reg;
    logic [38:0]        pk_lo_reg;
    logic [37:0]        pk_hi_reg;
    logic [29:0]        csq_reg;
    logic [31:0]        dsq_reg;
    logic signed [25:0] dh_reg;

    logic signed [31:0] head_reg;
    logic signed [31:0] lat_reg;
    logic [61:0]        lp_reg;
    logic [61:0]        hsq_reg;
    logic [61:0]        lsq_reg;
    logic [63:0]        cost_reg;
    logic [63:0]        min_cost_reg;
    logic signed [15:0] best_reg;
    logic signed [15:0] last_reg;

    logic signed [20:0] off_full;
    logic signed [20:0] off_half;
    logic signed [20:0] off;
    logic signed [20:0] csum;
    logic signed [20:0] lim;
    logic signed [15:0] c_next;
    logic [14:0]        cmag;
    logic [15:0]        dmag;
    logic [62:0]        pk_sum;
    logic [24:0]        dh_mag;
    logic [43:0]        c02;
    logic [30:0]        hmag;
    logic [30:0]        lmag;
    logic [37:0]        inc_mag;
    logic signed [39:0] inc;
    logic [45:0]        h16;
    logic [63:0]        lat_term;
    logic [63:0]        head_term;
    logic [63:0]        cost_fin;

    assign stat.dt_zero = (dt_reg == 16'd0);

    always_comb
    begin
        off_full = signed'({2'b00, full_reg});
        off_half = signed'({3'b000, half_reg});
        unique case (cmd.cand)
            mscs_pkg::CAND_NEG_FULL: off = -off_full;
            mscs_pkg::CAND_NEG_HALF: off = -off_half;
            mscs_pkg::CAND_ZERO:     off = 21'sd0;
            mscs_pkg::CAND_POS_HALF: off = off_half;
            mscs_pkg::CAND_POS_FULL: off = off_full;
            default:                 off = 21'sd0;
        endcase
        csum = 21'(last_reg) + off;
        lim  = signed'({6'b000000, max_steer_angle});
        if (csum > lim)
            c_next = lim[15:0];
        else if (csum < -lim)
            c_next = 16'(-lim);
        else
            c_next = csum[15:0];
    end

    assign cmag = c_reg[15] ? 15'(-c_reg) : c_reg[14:0];
    assign dmag = d_reg[16] ? 16'(-d_reg) : d_reg[15:0];

    // heading step: round(|c|*kin / 2^38), kin split at bit 24
    assign pk_sum = {1'b0, pk_hi_reg, 24'd0} + 63'(pk_lo_reg) + (63'd1 << 37);
    assign dh_mag = pk_sum[62:38];
    assign c02    = 44'(csq_reg) * 44'(mscs_pkg::COEF_POINT_TWO);

    assign hmag = head_reg[31] ? 31'(-head_reg) : head_reg[30:0];
    assign lmag = lat_reg[31] ? 31'(-lat_reg) : lat_reg[30:0];

    assign inc_mag = 38'((63'(lp_reg) + 63'd8388608) >> 24);
    assign inc     = head_reg[31] ? -signed'({2'b00, inc_mag}) : signed'({2'b00, inc_mag});

    assign h16       = hsq_reg[61:16];
    assign head_term = 64'(h16) + 64'({h16, 1'b0});
    assign lat_term  = 64'({lsq_reg[61:16], 3'b000});
    assign cost_fin  = mscs_pkg::sat_add64(cost_reg, lat_term);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lat0_reg  <= {{12{lateral_offset[15]}}, lateral_offset, 4'b0000};
            head0_reg <= {{14{head_error[15]}}, head_error, 2'b00};
            if (vehicle_speed < 16'sd256)
                speed_reg <= mscs_pkg::SPEED_FLOOR;
            else
                speed_reg <= vehicle_speed[14:0];
            dt_reg <= step_time;
        end
        if (cmd.prep1)
        begin
            prod_reg  <= 32'(max_steer_rate) * 32'(dt_reg);
            swb_reg   <= 31'(speed_reg) * 31'(inverse_wheelbase);
            lgain_reg <= 31'(speed_reg) * 31'(dt_reg);
        end
        if (cmd.prep2)
        begin
            full_reg <= 19'((33'(prod_reg) + 33'd8192) >> 14);
            half_reg <= 18'((33'(prod_reg) + 33'd16384) >> 15);
            kin_reg  <= 47'(swb_reg) * 47'(dt_reg);
        end
        if (cmd.cand_init)
        begin
            c_reg    <= c_next;
            d_reg    <= 17'(c_next) - 17'(last_reg);
            head_reg <= head0_reg;
            lat_reg  <= lat0_reg;
            lsq_reg  <= 62'd0;
        end
        if (cmd.cand_mul)
        begin
            pk_lo_reg <= 39'(cmag) * 39'(kin_reg[23:0]);
            pk_hi_reg <= 38'(cmag) * 38'(kin_reg[46:24]);
            csq_reg   <= 30'(cmag) * 30'(cmag);
            dsq_reg   <= 32'(dmag) * 32'(dmag);
        end
        if (cmd.cand_cost)
        begin
            dh_reg   <= c_reg[15] ? -signed'({1'b0, dh_mag}) : signed'({1'b0, dh_mag});
            cost_reg <= 64'(c02[43:28]) + 64'(dsq_reg[31:11]);
        end
        if (cmd.step_head)
        begin
            head_reg <= mscs_pkg::sat_model(40'(head_reg) + 40'(dh_reg));
            // lateral term of the previous step lands here
            cost_reg <= cost_fin;
        end
        if (cmd.step_mul)
        begin
            lp_reg  <= 62'(hmag) * 62'(lgain_reg);
            hsq_reg <= 62'(hmag) * 62'(hmag);
        end
        if (cmd.step_lat)
        begin
            lat_reg  <= mscs_pkg::sat_model(40'(lat_reg) + inc);
            cost_reg <= mscs_pkg::sat_add64(cost_reg, head_term);
        end
        if (cmd.step_sq)
            lsq_reg <= 62'(lmag) * 62'(lmag);
        if (cmd.cand_end && (cmd.first || (cost_fin < min_cost_reg)))
        begin
            min_cost_reg <= cost_fin;
            best_reg     <= c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 16'sd0;
        else if (cmd.commit && !stat.dt_zero)
            last_reg <= best_reg;
    end

    assign result_command = stat.dt_zero ? last_reg : best_reg;
    assign result_held    = stat.dt_zero;

endmodule

// ===== sv/mscs_ctrl.sv =====
`include "mpc_steering_candidate_search_defines.svh"

module mscs_ctrl #(
    parameter int HORIZON = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  out_free,
    input  mscs_pkg::mscs_stat_t  stat,
    output mscs_pkg::mscs_cmd_t   cmd,
    output logic                  in_ready
);

    localparam int STEP_W = (HORIZON > 1) ? $clog2(HORIZON) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HORIZON - 1);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_PREP1  = 12'b0000_0000_0010,
        ST_PREP2  = 12'b0000_0000_0100,
        ST_CINIT  = 12'b0000_0000_1000,
        ST_CMUL   = 12'b0000_0001_0000,
        ST_CCOST  = 12'b0000_0010_0000,
        ST_HEAD   = 12'b0000_0100_0000,
        ST_MUL    = 12'b0000_1000_0000,
        ST_LAT    = 12'b0001_0000_0000,
        ST_SQ     = 12'b0010_0000_0000,
        ST_CEND   = 12'b0100_0000_0000,
        ST_FINISH = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        cand_reg, cand_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        cand_next  = cand_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_PREP1;
            ST_PREP1:
                state_next = stat.dt_zero ? ST_FINISH : ST_PREP2;
            ST_PREP2:
            begin
                cand_next  = mscs_pkg::CAND_NEG_FULL;
                state_next = ST_CINIT;
            end
            ST_CINIT:
            begin
                step_next  = '0;
                state_next = ST_CMUL;
            end
            ST_CMUL:
                state_next = ST_CCOST;
            ST_CCOST:
                state_next = ST_HEAD;
            ST_HEAD:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_LAT;
            ST_LAT:
                state_next = ST_SQ;
            ST_SQ:
                if (step_reg == STEP_LAST)
                    state_next = ST_CEND;
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_HEAD;
                end
            ST_CEND:
                if (cand_reg == mscs_pkg::CAND_LAST)
                    state_next = ST_FINISH;
                else
                begin
                    cand_next  = cand_reg + 3'd1;
                    state_next = ST_CINIT;
                end
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cand_reg  <= mscs_pkg::CAND_NEG_FULL;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cand_reg  <= cand_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.prep1     = (state_reg == ST_PREP1);
        cmd.prep2     = (state_reg == ST_PREP2);
        cmd.cand_init = (state_reg == ST_CINIT);
        cmd.cand_mul  = (state_reg == ST_CMUL);
        cmd.cand_cost = (state_reg == ST_CCOST);
        cmd.step_head = (state_reg == ST_HEAD);
        cmd.step_mul  = (state_reg == ST_MUL);
        cmd.step_lat  = (state_reg == ST_LAT);
        cmd.step_sq   = (state_reg == ST_SQ);
        cmd.cand_end  = (state_reg == ST_CEND);
        cmd.commit    = (state_reg == ST_FINISH) && out_free;
        cmd.cand      = cand_reg;
        cmd.first     = (cand_reg == mscs_pkg::CAND_NEG_FULL);
    end

    `MSCS_ASSERT_ALWAYS(a_cand_range, cand_reg <= mscs_pkg::CAND_LAST, "candidate index out of range")
    `MSCS_ASSERT_ALWAYS(a_step_range, step_reg <= STEP_LAST, "horizon step out of range")
    `MSCS_ASSERT_NEXT(a_accept_prep, accept, state_reg == ST_PREP1, "accept did not start prep")
    `MSCS_ASSERT_IMPLY(a_commit_free, cmd.commit, out_free, "result committed over pending output")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int HZN = 10;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint SAT_MAX = 2147483647;
    localparam logic [1:0] REG_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    mpc_steering_candidate_search #(.HORIZON(HZN)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [15:0] cmd;
        logic        held;
    } steer_result_t;

    logic [63:0]   tick_queue[$];
    steer_result_t steer_expected[$];

    // predictor state
    longint unsigned rate_q;
    longint unsigned angle_q;
    longint unsigned iwb_q;
    longint          prev_cmd;

    int     errors;
    longint cycles;
    bit     idle_en;
    bit     sender_pause;
    int     hold_left;
    bit     hold_req;
    bit     s_tready_seen;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint clamp_l(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint round_scaled(longint x, longint unsigned k, int s);
        longint unsigned m;
        m = x < 0 ? longint'(-x) : longint'(x);
        m = (m * k + (64'd1 << (s - 1))) >> s;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return s < a ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned sq_mag(longint x);
        longint unsigned m;
        m = x < 0 ? longint'(-x) : longint'(x);
        return m * m;
    endfunction

    function automatic steer_result_t search_steer(logic [63:0] tick);
        steer_result_t   r;
        longint          lat0, head0, speed, full, half, c, d, lat, head, dh, best;
        longint          offs[5];
        longint unsigned dt, prod, kin, lgain, cost, min_cost;
        lat0  = longint'($signed(tick[15:0])) * 16;
        head0 = longint'($signed(tick[31:16])) * 4;
        speed = longint'($signed(tick[47:32]));
        dt    = 64'(tick[63:48]);
        best  = prev_cmd;
        min_cost = 0;
        if (dt == 0)
        begin
            r.cmd  = prev_cmd[15:0];
            r.held = 1'b1;
            return r;
        end
        if (speed < 256)
            speed = 256;
        prod = rate_q * dt;
        full = longint'((prod + (64'd1 << 13)) >> 14);
        half = longint'((prod + (64'd1 << 14)) >> 15);
        offs[0] = -full;
        offs[1] = -half;
        offs[2] = 0;
        offs[3] = half;
        offs[4] = full;
        kin   = longint'(speed) * iwb_q * dt;
        lgain = longint'(speed) * dt;
        for (int i = 0; i < 5; i++)
        begin
            c = clamp_l(prev_cmd + offs[i], -longint'(angle_q), longint'(angle_q));
            d = c - prev_cmd;
            lat = lat0;
            head = head0;
            dh = round_scaled(c, kin, 38);
            cost = ((sq_mag(c) * 13107) >> 28) + (sq_mag(d) >> 11);
            for (int s = 0; s < HZN; s++)
            begin
                head = clamp_l(head + dh, -SAT_MAX, SAT_MAX);
                lat = clamp_l(lat + round_scaled(head, lgain, 24), -SAT_MAX, SAT_MAX);
                cost = add_sat(cost, 8 * (sq_mag(lat) >> 16));
                cost = add_sat(cost, 3 * (sq_mag(head) >> 16));
            end
            if (i == 0 || cost < min_cost)
            begin
                min_cost = cost;
                best = c;
            end
        end
        prev_cmd = best;
        r.cmd  = best[15:0];
        r.held = 1'b0;
        return r;
    endfunction

    // predicts at the transfer edge
    always @(posedge clk)
    begin
        s_tready_seen <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (s_tvalid && s_tready)
                steer_expected.push_back(search_steer(s_tdata));
        end
    end

    // driver: the head of the queue stays offered until it transfers
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tready_seen)
                void'(tick_queue.pop_front());
            if (!s_tvalid || s_tready_seen)
            begin
                if (sender_pause || tick_queue.size() == 0)
                    s_tvalid <= 1'b0;
                else if (idle_en && $urandom_range(99) < 24)
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tick_queue[0];
                end
            end
        end
    end

    // receiver ready and long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req && hold_left == 0)
        begin
            hold_left <= 3000;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(idle_en && $urandom_range(99) < 24);
    end

    // monitor
    always @(posedge clk)
    begin
        steer_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (steer_expected.size() == 0)
            begin
                $display("%0t: unexpected result cmd=%h held=%b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = steer_expected.pop_front();
                if (m_tdata !== e.cmd)
                begin
                    $display("%0t: steer_command expected %h actual %h", $time, e.cmd, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== e.held)
                begin
                    $display("%0t: held expected %b actual %b", $time, e.held, m_tuser[0]);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("mpc_steering_candidate_search regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand_tick(bit sane);
        logic [15:0] lat, head, spd, dt;
        lat  = 16'($urandom);
        head = 16'($urandom);
        spd  = 16'($urandom);
        dt   = 16'($urandom);
        if (sane)
        begin
            lat  = 16'($signed($urandom_range(0, 8000)) - 4000);
            head = 16'($signed($urandom_range(0, 4000)) - 2000);
            spd  = 16'($urandom_range(0, 9000));
            dt   = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, 6600));
        end
        else if ($urandom_range(0, 9) == 0)
            dt = 16'd0;
        return {dt, spd, head, lat};
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            mscs_pkg::REG_RATE:  rate_q  = 64'(val);
            mscs_pkg::REG_ANGLE: angle_q = 64'(val[14:0]);
            mscs_pkg::REG_IWB:   iwb_q   = 64'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (tick_queue.size() != 0 || steer_expected.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        idle_en = 1'b0;
        sender_pause = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rate_q = 64'(mscs_pkg::RATE_RST);
        angle_q = 64'(mscs_pkg::ANGLE_RST);
        iwb_q = 64'(mscs_pkg::IWB_RST);
        prev_cmd = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed ticks at reset configuration
        tick_queue.push_back({16'd1000, 16'd5000, 16'd1000, 16'd500});
        tick_queue.push_back({16'd0, 16'd5000, 16'd1000, 16'd500});
        tick_queue.push_back({16'd655, 16'h8000, 16'h8000, 16'h8000});
        tick_queue.push_back({16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        tick_queue.push_back({16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000});
        tick_queue.push_back({16'd655, 16'd100, 16'd0, 16'd0});
        tick_queue.push_back({16'd655, 16'hFF00, 16'd0, 16'd0});
        tick_queue.push_back({16'd1, 16'd0, 16'd0, 16'd0});
        drain();

        cfg_write(mscs_pkg::REG_RATE, 16'hFFFF);
        cfg_write(mscs_pkg::REG_ANGLE, 16'h7FFF);
        cfg_write(mscs_pkg::REG_IWB, 16'hFFFF);
        tick_queue.push_back({16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        tick_queue.push_back({16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000});
        tick_queue.push_back({16'd3000, 16'd2000, 16'h7000, 16'h9000});
        drain();

        cfg_write(mscs_pkg::REG_RATE, 16'd0);
        cfg_write(mscs_pkg::REG_ANGLE, 16'd0);
        cfg_write(mscs_pkg::REG_IWB, 16'd0);
        cfg_write(REG_NONE, 16'h1234);
        tick_queue.push_back({16'd655, 16'd3000, 16'd100, 16'd100});
        tick_queue.push_back({16'd0, 16'd3000, 16'd100, 16'd100});
        drain();

        idle_en = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            cfg_write(mscs_pkg::REG_RATE, ph == 3 ? 16'hFFFF : 16'($urandom_range(0, 16000)));
            cfg_write(mscs_pkg::REG_ANGLE, ph == 2 ? 16'd1 : 16'($urandom_range(0, 32767)));
            cfg_write(mscs_pkg::REG_IWB, 16'($urandom_range(1, 65535)));
            for (int k = 0; k < 210; k++)
                tick_queue.push_back(rand_tick($urandom_range(0, 99) < 75));
            if (ph == 1)
            begin
                hold_req = 1'b1;
                @(posedge clk);
                hold_req = 1'b0;
            end
            if (ph == 2)
            begin
                while (tick_queue.size() > 100)
                    @(posedge clk);
                sender_pause = 1'b1;
                while (steer_expected.size() != 0)
                    @(posedge clk);
                sender_pause = 1'b0;
                idle_en = 1'b0;
            end
            drain();
            idle_en = 1'b1;
        end

        if (errors == 0)
            $display("mpc_steering_candidate_search regression: pass");
        else
            $display("mpc_steering_candidate_search regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/mscs_pkg.sv
sv/mscs_datapath.sv
sv/mscs_ctrl.sv
sv/mpc_steering_candidate_search.sv
tb/tb.sv
